>>> rtl/ias_pkg.sv
package ias_pkg;

	typedef enum logic [1:0] {
		OP_LOAD_DET = 2'd0,
		OP_LOAD_TRK = 2'd1,
		OP_SOLVE    = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	localparam int IDX_OUT_BITS = 6;

endpackage

>>> rtl/ias_ram.sv
module ias_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [ABITS-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [ABITS-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/iou_assignment_solver.sv
// Detection to tracker assignment by minimum IoU cost.
// Command channel: a request is taken when start is high and busy is low.
// op load-detection / load-tracker stores the box; busy stays low, so loads
// can be issued back to back. Loads beyond MAX_BOXES are dropped. op solve
// with any box loaded raises busy for the whole run, else it is ignored, as is
// an unused op. Solve builds the n x n cost matrix (n = larger count), one
// pair at a time: a real pair goes through read, geometry, multiply, union,
// the bit-serial IoU divider (skipped if the union is not positive) and
// write; a padded pair goes from read to write. The assignment then runs one
// row insertion per row, every step a read-modify-write on the potential,
// slack and column-owner memories. One result per column follows in column
// order, each through S_EM_P, S_EM_PW and S_EM_C, shown for one cycle with
// valid high; last marks the final one. The receiver cannot hold results off.
// After the run both box counts return to zero and busy falls. Reset clears
// the counts and the control state; the memories need no clearing.
module iou_assignment_solver #(
	parameter int MAX_BOXES     = 64,
	parameter int COORD_BITS    = 12,
	parameter int IOU_FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [1:0]               op,
	input  logic [COORD_BITS-1:0]    x_left,
	input  logic [COORD_BITS-1:0]    y_top,
	input  logic [COORD_BITS-1:0]    x_right,
	input  logic [COORD_BITS-1:0]    y_bottom,
	output logic                     busy,
	output logic                     valid,
	output logic [5:0]               tracker_index,
	output logic [5:0]               detection_index,
	output logic [IOU_FRAC_BITS:0]   overlap,
	output logic                     is_padding,
	output logic                     last
);

	localparam int MB  = MAX_BOXES;
	localparam int CB  = COORD_BITS;
	localparam int FB  = IOU_FRAC_BITS;
	localparam int IW  = $clog2(MB);
	localparam int CW  = $clog2(MB + 1);
	localparam int CAW = $clog2(MB * MB);
	localparam int GW  = CB + 2;
	localparam int PRW = 2 * GW;
	localparam int AW  = PRW + 1;
	localparam int QW  = FB + 1;
	localparam int PW  = QW + CW + 2;
	localparam int SW  = $clog2(QW + 1);
	localparam int BW  = 4 * CB;
	localparam int OW  = ias_pkg::IDX_OUT_BITS;

	localparam logic [QW-1:0]        ONE_Q = {1'b1, {FB{1'b0}}};
	localparam logic signed [PW-1:0] BIG   = {1'b0, {(PW-1){1'b1}}};

	typedef enum logic [4:0] {
		S_IDLE, S_B_RD, S_B_GEO, S_B_MUL, S_B_UNI, S_B_DIV, S_B_WR,
		S_INIT, S_ROW, S_CLR, S_P_RD, S_P_WT, S_U_RD, S_U_WT,
		S_SC_RD, S_SC_EV, S_SC_END, S_UP_RD, S_UP_EV, S_UP_U,
		S_AUG, S_AUG_WT, S_AUG_PT, S_EM_P, S_EM_PW, S_EM_C
	} state_t;

	state_t state_q;

	logic [CW-1:0] dc_q, tc_q, n_q;
	logic [CW-1:0] bi_q, bj_q, i_q, j_q, j0_q, j1_q, i0_q, pj_q, row_q;
	logic          first_q;
	logic [MB:0]   used_q;
	logic signed [PW-1:0] ui0_q, delta_q;
	logic [QW-1:0] cval_q;

	logic signed [GW-1:0]  iw_q, ih_q, wa_q, ha_q, wb_q, hb_q;
	logic signed [PRW-1:0] inter_q, aa_q, ab_q;
	logic [AW:0]           rem_q;
	logic [AW-1:0]         den_q;
	logic [QW-1:0]         q_q;
	logic [SW-1:0]         cnt_q;
	logic                  dfirst_q;

	logic          valid_q, pad_q, last_q;
	logic [OW-1:0] tidx_q, didx_q;
	logic [QW-1:0] ov_q;

	// memory ports
	logic          det_we, trk_we;
	logic [BW-1:0] box_in, det_rd, trk_rd;
	logic          cost_we;
	logic [CAW-1:0] cost_waddr, cost_raddr;
	logic [QW-1:0] cost_rd;
	logic          u_we, v_we, p_we, way_we, mv_we;
	logic [CW-1:0] u_waddr, u_raddr, p_waddr, p_raddr, p_wdata, way_wdata;
	logic signed [PW-1:0] u_wdata, v_wdata, mv_wdata;
	logic signed [PW-1:0] u_rd, v_rd, mv_rd;
	logic [CW-1:0] p_rd, way_rd;

	function automatic logic [CAW-1:0] caddr(input logic [CW-1:0] r, input logic [CW-1:0] c);
		caddr = CAW'(r) * CAW'(MB) + CAW'(c);
	endfunction

	assign box_in = {y_bottom, x_right, y_top, x_left};

	ias_ram #(.WIDTH(BW), .DEPTH(MB)) u_det_ram (
		.clk(clk), .we(det_we), .waddr(dc_q[IW-1:0]), .wdata(box_in),
		.raddr(bi_q[IW-1:0]), .rdata(det_rd)
	);
	ias_ram #(.WIDTH(BW), .DEPTH(MB)) u_trk_ram (
		.clk(clk), .we(trk_we), .waddr(tc_q[IW-1:0]), .wdata(box_in),
		.raddr(bj_q[IW-1:0]), .rdata(trk_rd)
	);
	ias_ram #(.WIDTH(QW), .DEPTH(MB * MB)) u_cost_ram (
		.clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(cval_q),
		.raddr(cost_raddr), .rdata(cost_rd)
	);
	ias_ram #(.WIDTH(PW), .DEPTH(MB + 1)) u_u_ram (
		.clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
		.raddr(u_raddr), .rdata(u_rd)
	);
	ias_ram #(.WIDTH(PW), .DEPTH(MB + 1)) u_v_ram (
		.clk(clk), .we(v_we), .waddr(j_q), .wdata(v_wdata),
		.raddr(j_q), .rdata(v_rd)
	);
	ias_ram #(.WIDTH(CW), .DEPTH(MB + 1)) u_p_ram (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rd)
	);
	ias_ram #(.WIDTH(CW), .DEPTH(MB + 1)) u_way_ram (
		.clk(clk), .we(way_we), .waddr(j_q), .wdata(way_wdata),
		.raddr(j0_q), .rdata(way_rd)
	);
	ias_ram #(.WIDTH(PW), .DEPTH(MB + 1)) u_mv_ram (
		.clk(clk), .we(mv_we), .waddr(j_q), .wdata(mv_wdata),
		.raddr(j_q), .rdata(mv_rd)
	);

	// geometry from the two box reads
	logic signed [GW-1:0] axl, ayt, axr, ayb, bxl, byt, bxr, byb;
	logic signed [GW-1:0] iw_raw, ih_raw;
	logic signed [AW-1:0] uni;
	logic [AW:0]          dv_t;
	logic                 dv_ge;
	logic signed [PW-1:0] cur;
	logic                 cur_lt;
	logic signed [PW-1:0] eff;
	logic [CW-1:0]        row_c;
	logic                 load_ok;

	always_comb begin
		axl = $signed({2'b00, det_rd[CB-1:0]});
		ayt = $signed({2'b00, det_rd[2*CB-1:CB]});
		axr = $signed({2'b00, det_rd[3*CB-1:2*CB]});
		ayb = $signed({2'b00, det_rd[4*CB-1:3*CB]});
		bxl = $signed({2'b00, trk_rd[CB-1:0]});
		byt = $signed({2'b00, trk_rd[2*CB-1:CB]});
		bxr = $signed({2'b00, trk_rd[3*CB-1:2*CB]});
		byb = $signed({2'b00, trk_rd[4*CB-1:3*CB]});
		iw_raw = ((axr < bxr) ? axr : bxr) - ((axl > bxl) ? axl : bxl) + GW'(1);
		ih_raw = ((ayb < byb) ? ayb : byb) - ((ayt > byt) ? ayt : byt) + GW'(1);
		uni = AW'(aa_q) + AW'(ab_q) - AW'(inter_q);
		dv_t = dfirst_q ? rem_q : {rem_q[AW-1:0], 1'b0};
		dv_ge = dv_t >= {1'b0, den_q};
		cur = $signed({{(PW-QW){1'b0}}, cost_rd}) - ui0_q - v_rd;
		cur_lt = cur < mv_rd;
		eff = cur_lt ? cur : mv_rd;
		row_c = (p_rd != '0) ? p_rd - CW'(1) : '0;
		load_ok = (state_q == S_IDLE) && start;
	end

	always_comb begin
		det_we = load_ok && (op == ias_pkg::OP_LOAD_DET) && (dc_q < CW'(MB));
		trk_we = load_ok && (op == ias_pkg::OP_LOAD_TRK) && (tc_q < CW'(MB));
		cost_we = (state_q == S_B_WR);
		cost_waddr = caddr(bi_q, bj_q);
		cost_raddr = (state_q == S_EM_PW) ? caddr(row_c, j_q)
			: caddr(i0_q - CW'(1), j_q - CW'(1));
		u_we = 1'b0;
		u_waddr = j_q;
		u_wdata = '0;
		u_raddr = (state_q == S_UP_EV) ? p_rd : i0_q;
		v_we = 1'b0;
		v_wdata = '0;
		p_we = 1'b0;
		p_waddr = j_q;
		p_wdata = '0;
		p_raddr = j_q;
		way_we = 1'b0;
		way_wdata = '0;
		mv_we = 1'b0;
		mv_wdata = BIG;
		unique case (state_q)
			S_INIT: begin
				u_we = 1'b1;
				v_we = 1'b1;
				p_we = 1'b1;
			end
			S_ROW: begin
				p_we = 1'b1;
				p_waddr = '0;
				p_wdata = i_q;
			end
			S_CLR: begin
				way_we = 1'b1;
				mv_we = 1'b1;
			end
			S_P_RD: p_raddr = j0_q;
			S_SC_EV: begin
				way_we = cur_lt;
				way_wdata = j0_q;
				mv_we = cur_lt;
				mv_wdata = cur;
			end
			S_UP_EV: begin
				v_we = used_q[j_q];
				v_wdata = v_rd - delta_q;
				mv_we = !used_q[j_q];
				mv_wdata = mv_rd - delta_q;
			end
			S_UP_U: begin
				u_we = 1'b1;
				u_waddr = pj_q;
				u_wdata = u_rd + delta_q;
			end
			S_AUG_WT: p_raddr = way_rd;
			S_AUG_PT: begin
				p_we = 1'b1;
				p_waddr = j0_q;
				p_wdata = p_rd;
			end
			S_EM_P: p_raddr = j_q + CW'(1);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dc_q <= '0;
			tc_q <= '0;
			n_q <= '0;
			bi_q <= '0;
			bj_q <= '0;
			i_q <= '0;
			j_q <= '0;
			j0_q <= '0;
			j1_q <= '0;
			i0_q <= '0;
			pj_q <= '0;
			row_q <= '0;
			first_q <= 1'b0;
			used_q <= '0;
			cnt_q <= '0;
			dfirst_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (det_we)
						dc_q <= dc_q + CW'(1);
					if (trk_we)
						tc_q <= tc_q + CW'(1);
					if (load_ok && op == ias_pkg::OP_SOLVE && (dc_q != '0 || tc_q != '0)) begin
						n_q <= (dc_q > tc_q) ? dc_q : tc_q;
						bi_q <= '0;
						bj_q <= '0;
						state_q <= S_B_RD;
					end
				end
				S_B_RD: begin
					if (bi_q < dc_q && bj_q < tc_q) begin
						state_q <= S_B_GEO;
					end else begin
						cval_q <= '0;
						state_q <= S_B_WR;
					end
				end
				S_B_GEO: begin
					iw_q <= (iw_raw > 0) ? iw_raw : '0;
					ih_q <= (ih_raw > 0) ? ih_raw : '0;
					wa_q <= axr - axl + GW'(1);
					ha_q <= ayb - ayt + GW'(1);
					wb_q <= bxr - bxl + GW'(1);
					hb_q <= byb - byt + GW'(1);
					state_q <= S_B_MUL;
				end
				S_B_MUL: begin
					inter_q <= iw_q * ih_q;
					aa_q <= wa_q * ha_q;
					ab_q <= wb_q * hb_q;
					state_q <= S_B_UNI;
				end
				S_B_UNI: begin
					if (uni <= 0) begin
						cval_q <= ONE_Q;
						state_q <= S_B_WR;
					end else begin
						rem_q <= (AW + 1)'($unsigned(inter_q));
						den_q <= $unsigned(uni);
						q_q <= '0;
						cnt_q <= '0;
						dfirst_q <= 1'b1;
						state_q <= S_B_DIV;
					end
				end
				S_B_DIV: begin
					dfirst_q <= 1'b0;
					rem_q <= dv_ge ? dv_t - {1'b0, den_q} : dv_t;
					q_q <= {q_q[QW-2:0], dv_ge};
					cnt_q <= cnt_q + SW'(1);
					if (cnt_q == SW'(QW - 1)) begin
						cval_q <= ONE_Q - {q_q[QW-2:0], dv_ge};
						state_q <= S_B_WR;
					end
				end
				S_B_WR: begin
					if (bj_q == n_q - CW'(1)) begin
						bj_q <= '0;
						bi_q <= bi_q + CW'(1);
						if (bi_q == n_q - CW'(1)) begin
							j_q <= '0;
							state_q <= S_INIT;
						end else begin
							state_q <= S_B_RD;
						end
					end else begin
						bj_q <= bj_q + CW'(1);
						state_q <= S_B_RD;
					end
				end
				S_INIT: begin
					if (j_q == n_q) begin
						i_q <= CW'(1);
						state_q <= S_ROW;
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				S_ROW: begin
					used_q <= '0;
					j_q <= '0;
					state_q <= S_CLR;
				end
				S_CLR: begin
					if (j_q == n_q) begin
						j0_q <= '0;
						first_q <= 1'b1;
						state_q <= S_P_RD;
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				S_P_RD: state_q <= S_P_WT;
				S_P_WT: begin
					if (!first_q && p_rd == '0) begin
						state_q <= S_AUG;
					end else begin
						i0_q <= p_rd;
						used_q[j0_q] <= 1'b1;
						first_q <= 1'b0;
						state_q <= S_U_RD;
					end
				end
				S_U_RD: state_q <= S_U_WT;
				S_U_WT: begin
					ui0_q <= u_rd;
					j_q <= CW'(1);
					delta_q <= BIG;
					j1_q <= '0;
					state_q <= S_SC_RD;
				end
				S_SC_RD: begin
					if (!used_q[j_q])
						state_q <= S_SC_EV;
					else if (j_q == n_q)
						state_q <= S_SC_END;
					else
						j_q <= j_q + CW'(1);
				end
				S_SC_EV: begin
					if (eff < delta_q) begin
						delta_q <= eff;
						j1_q <= j_q;
					end
					if (j_q == n_q) begin
						state_q <= S_SC_END;
					end else begin
						j_q <= j_q + CW'(1);
						state_q <= S_SC_RD;
					end
				end
				S_SC_END: begin
					if (j1_q == '0) begin
						state_q <= S_AUG;
					end else begin
						j_q <= '0;
						state_q <= S_UP_RD;
					end
				end
				S_UP_RD: state_q <= S_UP_EV;
				S_UP_EV, S_UP_U: begin
					if (state_q == S_UP_EV && used_q[j_q]) begin
						pj_q <= p_rd;
						state_q <= S_UP_U;
					end else if (j_q == n_q) begin
						j0_q <= j1_q;
						state_q <= S_P_RD;
					end else begin
						j_q <= j_q + CW'(1);
						state_q <= S_UP_RD;
					end
				end
				S_AUG: begin
					if (j0_q != '0) begin
						state_q <= S_AUG_WT;
					end else if (i_q == n_q) begin
						j_q <= '0;
						state_q <= S_EM_P;
					end else begin
						i_q <= i_q + CW'(1);
						state_q <= S_ROW;
					end
				end
				S_AUG_WT: begin
					j1_q <= way_rd;
					state_q <= S_AUG_PT;
				end
				S_AUG_PT: begin
					j0_q <= j1_q;
					state_q <= S_AUG;
				end
				S_EM_P: state_q <= S_EM_PW;
				S_EM_PW: begin
					row_q <= row_c;
					state_q <= S_EM_C;
				end
				S_EM_C: begin
					valid_q <= 1'b1;
					tidx_q <= OW'(j_q);
					didx_q <= OW'(row_q);
					pad_q <= !(row_q < dc_q && j_q < tc_q);
					ov_q <= (row_q < dc_q && j_q < tc_q) ? ONE_Q - cost_rd : '0;
					last_q <= (j_q == n_q - CW'(1));
					if (j_q == n_q - CW'(1)) begin
						dc_q <= '0;
						tc_q <= '0;
						state_q <= S_IDLE;
					end else begin
						j_q <= j_q + CW'(1);
						state_q <= S_EM_P;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign valid = valid_q;
	assign tracker_index = tidx_q;
	assign detection_index = didx_q;
	assign overlap = ov_q;
	assign is_padding = pad_q;
	assign last = valid_q & last_q;

	a_result_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |-> busy)
		else $error("result strobe outside a solve run");

	a_scan_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SC_EV) |-> !used_q[j_q])
		else $error("scan evaluated a column already in the tree");

	a_overlap_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (overlap <= ONE_Q))
		else $error("overlap above one");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && is_padding |-> (overlap == '0))
		else $error("padding result with nonzero overlap");

	a_counts_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |-> (dc_q == '0 && tc_q == '0))
		else $error("counts not cleared after solve");

endmodule

>>> test/iou_assignment_checker.sv
`timescale 1ns / 100ps

module iou_assignment_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  op,
	input  logic [11:0] x_left,
	input  logic [11:0] y_top,
	input  logic [11:0] x_right,
	input  logic [11:0] y_bottom,
	input  logic        valid,
	input  logic [5:0]  tracker_index,
	input  logic [5:0]  detection_index,
	input  logic [16:0] overlap,
	input  logic        is_padding,
	input  logic        last,
	output int          fail_count,
	output int          pending,
	output logic        accepted
);

	localparam int NBOX = 64;
	localparam longint ONE_Q = 64'd65536;
	localparam longint HUGE = 64'sd1 << 60;

	typedef struct packed {
		logic [5:0]  trk;
		logic [5:0]  det;
		logic [16:0] ov;
		logic        pad;
		logic        fin;
	} assignment_t;

	logic [47:0] det_box [NBOX];
	logic [47:0] trk_box [NBOX];
	int det_n, trk_n;
	longint cost [NBOX*NBOX];
	longint u_pot [NBOX+1], v_pot [NBOX+1], slack [NBOX+1];
	int owner [NBOX+1], back [NBOX+1];
	bit used [NBOX+1];
	assignment_t expected_assignments [$];

	function automatic longint pair_overlap(logic [47:0] a, logic [47:0] b);
		longint axl, ayt, axr, ayb, bxl, byt, bxr, byb, iw, ih, inter, uni, q;
		axl = a[11:0]; ayt = a[23:12]; axr = a[35:24]; ayb = a[47:36];
		bxl = b[11:0]; byt = b[23:12]; bxr = b[35:24]; byb = b[47:36];
		iw = ((axr < bxr) ? axr : bxr) - ((axl > bxl) ? axl : bxl) + 1;
		ih = ((ayb < byb) ? ayb : byb) - ((ayt > byt) ? ayt : byt) + 1;
		if (iw < 0) iw = 0;
		if (ih < 0) ih = 0;
		inter = iw * ih;
		uni = (axr - axl + 1) * (ayb - ayt + 1) + (bxr - bxl + 1) * (byb - byt + 1) - inter;
		if (uni <= 0)
			return 0;
		q = (inter << 16) / uni;
		return (q > ONE_Q) ? ONE_Q : q;
	endfunction

	task automatic solve_frame();
		int n, i, j, j0, j1, i0, r;
		longint delta, cur;
		assignment_t a;
		n = (det_n > trk_n) ? det_n : trk_n;
		for (i = 0; i < n; i++)
			for (j = 0; j < n; j++)
				cost[i*n+j] = (i < det_n && j < trk_n) ?
					ONE_Q - pair_overlap(det_box[i], trk_box[j]) : 0;
		for (j = 0; j <= n; j++) begin
			u_pot[j] = 0; v_pot[j] = 0; owner[j] = 0;
		end
		for (i = 1; i <= n; i++) begin
			j0 = 0;
			owner[0] = i;
			for (j = 0; j <= n; j++) begin
				slack[j] = HUGE; used[j] = 0; back[j] = 0;
			end
			do begin
				i0 = owner[j0];
				j1 = 0;
				delta = HUGE;
				used[j0] = 1;
				for (j = 1; j <= n; j++)
					if (!used[j]) begin
						cur = cost[(i0-1)*n+j-1] - u_pot[i0] - v_pot[j];
						if (cur < slack[j]) begin
							slack[j] = cur; back[j] = j0;
						end
						if (slack[j] < delta) begin
							delta = slack[j]; j1 = j;
						end
					end
				if (j1 == 0) break;
				for (j = 0; j <= n; j++)
					if (used[j]) begin
						u_pot[owner[j]] += delta; v_pot[j] -= delta;
					end else
						slack[j] -= delta;
				j0 = j1;
			end while (owner[j0] != 0);
			while (j0 != 0) begin
				j1 = back[j0];
				owner[j0] = owner[j1];
				j0 = j1;
			end
		end
		for (j = 0; j < n; j++) begin
			r = (owner[j+1] > 0) ? owner[j+1] - 1 : 0;
			a.trk = j[5:0];
			a.det = r[5:0];
			a.pad = !(r < det_n && j < trk_n);
			a.ov = a.pad ? 17'd0 : 17'(ONE_Q - cost[r*n+j]);
			a.fin = (j + 1 == n);
			expected_assignments.push_back(a);
		end
		det_n = 0;
		trk_n = 0;
	endtask

	assign accepted = start && !busy;

	always @(posedge clk or negedge arst_n) begin
		assignment_t e, got;
		if (!arst_n) begin
			det_n = 0;
			trk_n = 0;
			fail_count = 0;
			expected_assignments.delete();
			pending = 0;
		end else begin
			if (valid) begin
				got = '{tracker_index, detection_index, overlap, is_padding, last};
				if (expected_assignments.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %p", got);
				end else begin
					e = expected_assignments.pop_front();
					if (got !== e) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p, got %p", e, got);
					end
				end
			end
			if (start && !busy) begin
				case (ias_pkg::op_t'(op))
					ias_pkg::OP_LOAD_DET: if (det_n < NBOX) begin
						det_box[det_n] = {y_bottom, x_right, y_top, x_left};
						det_n++;
					end
					ias_pkg::OP_LOAD_TRK: if (trk_n < NBOX) begin
						trk_box[trk_n] = {y_bottom, x_right, y_top, x_left};
						trk_n++;
					end
					ias_pkg::OP_SOLVE: solve_frame();
					default: ;
				endcase
			end
			pending = expected_assignments.size();
		end
	end

endmodule

>>> test/iou_assignment_solver_tb.sv
`timescale 1ns / 100ps

module iou_assignment_solver_tb;

	logic clk, arst_n, start, busy, valid, is_padding, last, accepted;
	logic [1:0] op;
	logic [11:0] x_left, y_top, x_right, y_bottom;
	logic [5:0] tracker_index, detection_index;
	logic [16:0] overlap;
	int fail_count, pending, idle_cycles, sent;

	iou_assignment_solver i_dut (.*);

	iou_assignment_checker i_checker (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (accepted || valid || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 10000000) begin
			$display("iou_assignment_solver_tb failed");
			$finish;
		end
	end

	// one request, held until taken; optional gap after
	task automatic send_request(ias_pkg::op_t o, logic [11:0] xl, yt, xr, yb);
		op <= o; x_left <= xl; y_top <= yt; x_right <= xr; y_bottom <= yb;
		start <= 1;
		do @(posedge clk); while (busy);
		sent++;
		if ($urandom_range(0, 3) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_box(ias_pkg::op_t o);
		logic [11:0] xl, yt;
		case ($urandom_range(0, 5))
			0: send_request(o, 12'($urandom), 12'($urandom), 12'($urandom),
				12'($urandom));
			1: send_request(o, 12'hfff, 12'hfff, 0, 0);
			default: begin
				xl = 12'($urandom_range(0, 3900));
				yt = 12'($urandom_range(0, 3900));
				send_request(o, xl, yt, 12'(xl + $urandom_range(0, 195)),
					12'(yt + $urandom_range(0, 195)));
			end
		endcase
	endtask

	task automatic send_frame(int nd, int nt);
		repeat (nd) send_box(ias_pkg::OP_LOAD_DET);
		repeat (nt) send_box(ias_pkg::OP_LOAD_TRK);
		if ($urandom_range(0, 15) == 0)
			send_request(ias_pkg::OP_NONE, 12'($urandom), 12'($urandom),
				12'($urandom), 12'($urandom));
		send_request(ias_pkg::OP_SOLVE, 12'($urandom), 12'($urandom),
			12'($urandom), 12'($urandom));
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		op = ias_pkg::OP_NONE;
		x_left = 0; y_top = 0; x_right = 0; y_bottom = 0;
		sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: empty solve, identical boxes, full-frame, inverted, disjoint
		send_request(ias_pkg::OP_SOLVE, 0, 0, 0, 0);
		send_request(ias_pkg::OP_NONE, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
		send_request(ias_pkg::OP_LOAD_DET, 0, 0, 12'hfff, 12'hfff);
		send_request(ias_pkg::OP_LOAD_DET, 10, 10, 20, 20);
		send_request(ias_pkg::OP_LOAD_DET, 12'hfff, 12'hfff, 0, 0);
		send_request(ias_pkg::OP_LOAD_TRK, 0, 0, 12'hfff, 12'hfff);
		send_request(ias_pkg::OP_LOAD_TRK, 15, 15, 30, 30);
		send_request(ias_pkg::OP_SOLVE, 0, 0, 0, 0);
		send_request(ias_pkg::OP_LOAD_TRK, 100, 100, 100, 100);
		send_request(ias_pkg::OP_LOAD_TRK, 12'hfff, 0, 12'hfff, 0);
		send_request(ias_pkg::OP_LOAD_DET, 100, 100, 100, 100);
		send_request(ias_pkg::OP_SOLVE, 0, 0, 0, 0);
		send_request(ias_pkg::OP_LOAD_DET, 5, 5, 2, 9);
		send_request(ias_pkg::OP_LOAD_TRK, 3, 3, 1, 1);
		send_request(ias_pkg::OP_SOLVE, 0, 0, 0, 0);
		// capacity: 66 detection loads, two dropped
		send_frame(66, 2);
		while (sent < 150) begin
			if ($urandom_range(0, 1))
				send_frame($urandom_range(0, 6), $urandom_range(0, 6));
			else
				send_frame($urandom_range(1, 12), $urandom_range(1, 12));
			if ($urandom_range(0, 4) == 0) begin
				start <= 0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
		send_frame(64, 64);
		start <= 0;
		@(posedge clk);
		while (busy || pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("iou_assignment_solver_tb passed");
		else
			$display("iou_assignment_solver_tb failed");
		$finish;
	end

endmodule
